@@ hdl/rtss_pkg.sv @@
// ---------------------------------------------------------------------------
// Resistive touch scan sequencer package
// Shared types, drive patterns, phase codes and reset values for the touch
// scan controller and its datapath.
// ---------------------------------------------------------------------------
package rtss_pkg;

  localparam int unsigned SampleBitsDefault = 10;
  localparam int unsigned ChanBits          = 3;
  localparam int unsigned PhaseBits         = 4;
  localparam int unsigned CfgIndexBits      = 4;
  localparam int unsigned PressureBits      = 16;

  localparam logic [PhaseBits-1:0] PhInit    = 4'd0;
  localparam logic [PhaseBits-1:0] PhStandby = 4'd1;
  localparam logic [PhaseBits-1:0] PhX       = 4'd3;
  localparam logic [PhaseBits-1:0] PhY       = 4'd5;
  localparam logic [PhaseBits-1:0] PhZ1      = 4'd7;
  localparam logic [PhaseBits-1:0] PhZ2      = 4'd9;
  localparam logic [PhaseBits-1:0] PhPot     = 4'd11;
  localparam logic [PhaseBits-1:0] PhLast    = 4'd12;

  localparam logic [CfgIndexBits-1:0] CfgRight  = 4'd0;
  localparam logic [CfgIndexBits-1:0] CfgTop    = 4'd1;
  localparam logic [CfgIndexBits-1:0] CfgBottom = 4'd2;
  localparam logic [CfgIndexBits-1:0] CfgPot    = 4'd3;

  localparam logic [ChanBits-1:0] ChanRightRst  = 3'd0;
  localparam logic [ChanBits-1:0] ChanTopRst    = 3'd3;
  localparam logic [ChanBits-1:0] ChanBottomRst = 3'd2;
  localparam logic [ChanBits-1:0] ChanPotRst    = 3'd4;

  localparam logic [PressureBits-1:0] PressureMax = 16'hFFFF;

  typedef enum logic [1:0] {
    DRV_HIZ,
    DRV_GND,
    DRV_VCC,
    DRV_PUL
  } drive_e;

  typedef struct packed {
    drive_e bottom;
    drive_e top;
    drive_e right;
    drive_e left;
  } pins_t;

  localparam pins_t PatStandby = '{bottom: DRV_PUL, top: DRV_HIZ, right: DRV_HIZ, left: DRV_GND};
  localparam pins_t PatX       = '{bottom: DRV_HIZ, top: DRV_HIZ, right: DRV_VCC, left: DRV_GND};
  localparam pins_t PatY       = '{bottom: DRV_VCC, top: DRV_GND, right: DRV_HIZ, left: DRV_HIZ};
  localparam pins_t PatZ       = '{bottom: DRV_VCC, top: DRV_HIZ, right: DRV_HIZ, left: DRV_GND};

  typedef enum logic [2:0] {
    RD_STANDBY,
    RD_X,
    RD_Y,
    RD_Z1,
    RD_Z2,
    RD_POT
  } reading_e;

  typedef enum logic [1:0] {
    MUX_RIGHT,
    MUX_TOP,
    MUX_BOTTOM,
    MUX_POT
  } mux_src_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic     store;
    reading_e slot;
    logic     drive_load;
    pins_t    drive_pat;
    logic     mux_load;
    mux_src_e mux_src;
    logic     mul;
    logic     div_step;
    logic     finish;
  } cmd_t;

endpackage

@@ hdl/rtss_ctrl.sv @@
// ---------------------------------------------------------------------------
// Touch scan controller
// Tracks the scan phase, decodes the per-phase actions and sequences the
// multiply and serial divide that produce the pressure estimate.
// ---------------------------------------------------------------------------
module rtss_ctrl #(
  parameter int unsigned SAMPLE_BITS = rtss_pkg::SampleBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rtss_pkg::cmd_t cmd_o
);

  localparam int unsigned DivSteps = 2 * SAMPLE_BITS;
  localparam int unsigned CntBits  = $clog2(DivSteps);
  localparam logic [CntBits-1:0] CntLast = CntBits'(DivSteps - 1);

  rtss_pkg::ctrl_state_e state_q, state_d;
  logic [rtss_pkg::PhaseBits-1:0] phase_q, phase_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;
  logic out_acc;
  rtss_pkg::cmd_t act;

  assign in_ready_o  = (state_q == rtss_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;

  // Phase action decode.
  always_comb begin
    act            = '0;
    act.slot       = rtss_pkg::RD_STANDBY;
    act.drive_pat  = rtss_pkg::PatStandby;
    act.mux_src    = rtss_pkg::MUX_BOTTOM;
    case (phase_q)
      rtss_pkg::PhStandby: begin
        act.store      = 1'b1;
        act.slot       = rtss_pkg::RD_STANDBY;
        act.drive_load = 1'b1;
        act.drive_pat  = rtss_pkg::PatX;
      end
      rtss_pkg::PhX: begin
        act.store      = 1'b1;
        act.slot       = rtss_pkg::RD_X;
        act.drive_load = 1'b1;
        act.drive_pat  = rtss_pkg::PatY;
        act.mux_load   = 1'b1;
        act.mux_src    = rtss_pkg::MUX_RIGHT;
      end
      rtss_pkg::PhY: begin
        act.store      = 1'b1;
        act.slot       = rtss_pkg::RD_Y;
        act.drive_load = 1'b1;
        act.drive_pat  = rtss_pkg::PatZ;
      end
      rtss_pkg::PhZ1: begin
        act.store      = 1'b1;
        act.slot       = rtss_pkg::RD_Z1;
        act.drive_load = 1'b1;
        act.drive_pat  = rtss_pkg::PatZ;
        act.mux_load   = 1'b1;
        act.mux_src    = rtss_pkg::MUX_TOP;
      end
      rtss_pkg::PhZ2: begin
        act.store      = 1'b1;
        act.slot       = rtss_pkg::RD_Z2;
        act.drive_load = 1'b1;
        act.drive_pat  = rtss_pkg::PatStandby;
        act.mux_load   = 1'b1;
        act.mux_src    = rtss_pkg::MUX_POT;
      end
      rtss_pkg::PhPot: begin
        act.store      = 1'b1;
        act.slot       = rtss_pkg::RD_POT;
        act.drive_load = 1'b1;
        act.drive_pat  = rtss_pkg::PatStandby;
        act.mux_load   = 1'b1;
        act.mux_src    = rtss_pkg::MUX_BOTTOM;
      end
      default: begin
        act.store = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_acc;
    case (state_q)
      rtss_pkg::ST_IDLE: begin
        if (in_acc) begin
          phase_d = (phase_q >= rtss_pkg::PhLast) ? rtss_pkg::PhStandby
                                                   : phase_q + 1'b1;
          if (phase_q == rtss_pkg::PhZ2) begin
            state_d = rtss_pkg::ST_MUL;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      rtss_pkg::ST_MUL: begin
        cnt_d   = '0;
        state_d = rtss_pkg::ST_DIV;
      end
      rtss_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = rtss_pkg::ST_FIN;
        end
      end
      rtss_pkg::ST_FIN: begin
        out_valid_d = 1'b1;
        state_d     = rtss_pkg::ST_IDLE;
      end
      default: begin
        state_d = rtss_pkg::ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o           = act;
    cmd_o.store     = 1'b0;
    cmd_o.drive_load = 1'b0;
    cmd_o.mux_load  = 1'b0;
    cmd_o.mul       = 1'b0;
    cmd_o.div_step  = 1'b0;
    cmd_o.finish    = 1'b0;
    case (state_q)
      rtss_pkg::ST_IDLE: begin
        cmd_o.store      = act.store && in_acc;
        cmd_o.drive_load = act.drive_load && in_acc;
        cmd_o.mux_load   = act.mux_load && in_acc;
      end
      rtss_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      rtss_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      rtss_pkg::ST_FIN: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        cmd_o.finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtss_pkg::ST_IDLE;
      phase_q     <= rtss_pkg::PhInit;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/rtss_datapath.sv @@
// ---------------------------------------------------------------------------
// Touch scan datapath
// Holds the channel registers, stored readings, pin drives and converter
// channel, and computes pressure with a multiplier and a restoring divider.
// ---------------------------------------------------------------------------
module rtss_datapath #(
  parameter int unsigned SAMPLE_BITS = rtss_pkg::SampleBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rtss_pkg::cmd_t                      cmd_i,
  input  logic [SAMPLE_BITS-1:0]              sample_i,
  input  logic                                cfg_we_i,
  input  logic [rtss_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [rtss_pkg::ChanBits-1:0]       cfg_data_i,
  output rtss_pkg::pins_t                     pins_o,
  output logic [rtss_pkg::ChanBits-1:0]       mux_channel_o,
  output logic [SAMPLE_BITS-1:0]              standby_reading_o,
  output logic [SAMPLE_BITS-1:0]              x_reading_o,
  output logic [SAMPLE_BITS-1:0]              y_reading_o,
  output logic [SAMPLE_BITS-1:0]              z1_reading_o,
  output logic [SAMPLE_BITS-1:0]              z2_reading_o,
  output logic [SAMPLE_BITS-1:0]              pot_reading_o,
  output logic [rtss_pkg::PressureBits-1:0]   pressure_o
);

  localparam int unsigned NumBits = 2 * SAMPLE_BITS;

  logic [rtss_pkg::ChanBits-1:0] ch_right_q, ch_top_q, ch_bottom_q, ch_pot_q;
  logic [SAMPLE_BITS-1:0] rd_q [6];
  rtss_pkg::pins_t pins_q;
  logic [rtss_pkg::ChanBits-1:0] mux_q, mux_d;
  logic [rtss_pkg::PressureBits-1:0] pres_q, pres_d;
  logic [NumBits-1:0] num_q;
  logic [SAMPLE_BITS-1:0] rem_q;
  logic [SAMPLE_BITS-1:0] z1, z2, xr, diff;
  logic [SAMPLE_BITS:0] trial, trial_sub;
  logic ge;

  assign xr   = rd_q[rtss_pkg::RD_X];
  assign z1   = rd_q[rtss_pkg::RD_Z1];
  assign z2   = rd_q[rtss_pkg::RD_Z2];
  assign diff = z2 - z1;

  assign trial     = {rem_q, num_q[NumBits-1]};
  assign trial_sub = trial - {1'b0, z1};
  assign ge        = trial >= {1'b0, z1};

  always_comb begin
    case (cmd_i.mux_src)
      rtss_pkg::MUX_RIGHT:  mux_d = ch_right_q;
      rtss_pkg::MUX_TOP:    mux_d = ch_top_q;
      rtss_pkg::MUX_BOTTOM: mux_d = ch_bottom_q;
      rtss_pkg::MUX_POT:    mux_d = ch_pot_q;
      default:              mux_d = ch_bottom_q;
    endcase
  end

  always_comb begin
    if (z1 == '0) begin
      pres_d = rtss_pkg::PressureMax;
    end else if (z2 < z1) begin
      pres_d = '0;
    end else if ((num_q >> rtss_pkg::PressureBits) != '0) begin
      pres_d = rtss_pkg::PressureMax;
    end else begin
      pres_d = num_q[rtss_pkg::PressureBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_right_q  <= rtss_pkg::ChanRightRst;
      ch_top_q    <= rtss_pkg::ChanTopRst;
      ch_bottom_q <= rtss_pkg::ChanBottomRst;
      ch_pot_q    <= rtss_pkg::ChanPotRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rtss_pkg::CfgRight:  ch_right_q  <= cfg_data_i;
        rtss_pkg::CfgTop:    ch_top_q    <= cfg_data_i;
        rtss_pkg::CfgBottom: ch_bottom_q <= cfg_data_i;
        rtss_pkg::CfgPot:    ch_pot_q    <= cfg_data_i;
        default:             ch_pot_q    <= ch_pot_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        rd_q[i] <= '0;
      end
      pins_q <= rtss_pkg::PatStandby;
      mux_q  <= rtss_pkg::ChanBottomRst;
      pres_q <= '0;
    end else begin
      if (cmd_i.store) begin
        rd_q[cmd_i.slot] <= sample_i;
      end
      if (cmd_i.drive_load) begin
        pins_q <= cmd_i.drive_pat;
      end
      if (cmd_i.mux_load) begin
        mux_q <= mux_d;
      end
      if (cmd_i.finish) begin
        pres_q <= pres_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      num_q <= diff * xr;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NumBits-2:0], ge};
      rem_q <= ge ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
    end
  end

  assign pins_o            = pins_q;
  assign mux_channel_o     = mux_q;
  assign standby_reading_o = rd_q[rtss_pkg::RD_STANDBY];
  assign x_reading_o       = rd_q[rtss_pkg::RD_X];
  assign y_reading_o       = rd_q[rtss_pkg::RD_Y];
  assign z1_reading_o      = rd_q[rtss_pkg::RD_Z1];
  assign z2_reading_o      = rd_q[rtss_pkg::RD_Z2];
  assign pot_reading_o     = rd_q[rtss_pkg::RD_POT];
  assign pressure_o        = pres_q;

endmodule

@@ hdl/resistive_touch_scan_sequencer.sv @@
// The result is registered for most phases; in the Z2 phase it follows the
// multiply, the one-bit-per-cycle restoring divider and a finish state.
// Throughput: one item per cycle outside the Z2 phase while out_ready_i holds;
// one input is taken per output delivered; the divider is the only multi-cycle unit.
// Reset: asynchronous active low; phase 0, readings and pressure cleared,
// standby drive pattern, default channel map, no result pending.
// ---------------------------------------------------------------------------
// Resistive touch scan sequencer
// Steps a four-wire panel through its scan phases, one converter sample per
// item, and reports the drive pattern, channel, readings and pressure.
// ---------------------------------------------------------------------------
module resistive_touch_scan_sequencer #(
  parameter int unsigned SAMPLE_BITS = rtss_pkg::SampleBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        drive_left_o,
  output logic [1:0]                        drive_right_o,
  output logic [1:0]                        drive_top_o,
  output logic [1:0]                        drive_bottom_o,
  output logic [rtss_pkg::ChanBits-1:0]     mux_channel_o,
  output logic [SAMPLE_BITS-1:0]            standby_reading_o,
  output logic [SAMPLE_BITS-1:0]            x_reading_o,
  output logic [SAMPLE_BITS-1:0]            y_reading_o,
  output logic [SAMPLE_BITS-1:0]            z1_reading_o,
  output logic [SAMPLE_BITS-1:0]            z2_reading_o,
  output logic [rtss_pkg::PressureBits-1:0] pressure_o,
  output logic [SAMPLE_BITS-1:0]            pot_reading_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rtss_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [rtss_pkg::ChanBits-1:0]     cfg_data_i
);

  rtss_pkg::cmd_t  cmd;
  rtss_pkg::pins_t pins;

  assign cfg_ready_o = 1'b1;

  rtss_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  rtss_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sample_i         (sample_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pins_o           (pins),
    .mux_channel_o    (mux_channel_o),
    .standby_reading_o(standby_reading_o),
    .x_reading_o      (x_reading_o),
    .y_reading_o      (y_reading_o),
    .z1_reading_o     (z1_reading_o),
    .z2_reading_o     (z2_reading_o),
    .pot_reading_o    (pot_reading_o),
    .pressure_o       (pressure_o)
  );

  assign drive_left_o   = pins.left;
  assign drive_right_o  = pins.right;
  assign drive_top_o    = pins.top;
  assign drive_bottom_o = pins.bottom;

endmodule
